// ===== rtl/wfs_pkg.sv =====
package wfs_pkg;

  localparam logic [7:0] NearGuessLimit = 8'd20;
  localparam logic [7:0] TooCloseLimit  = 8'd7;
  localparam logic [7:0] FarLimit       = 8'd60;
  localparam logic [7:0] InvalidError   = 8'd50;
  localparam logic [3:0] HardTurnSpeed  = 4'd15;
  localparam logic [3:0] CloseTurn      = 4'd8;
  localparam logic [3:0] FarGuessTurn   = 4'd10;
  localparam logic [2:0] CooldownReady  = 3'd4;

  localparam int unsigned PaddrWidth = 4;

  typedef enum logic [1:0] {
    REG_TARGET_DISTANCE = 2'd0,
    REG_FORWARD_SPEED   = 2'd1,
    REG_ERROR_TOLERANCE = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic [7:0] target_distance;
    logic [7:0] forward_speed;
    logic [7:0] error_tolerance;
  } cfg_t;

  typedef struct packed {
    logic       wall_side;
    logic [7:0] distance;
    logic       reading_valid;
    logic       wall_change_active;
  } item_t;

  typedef struct packed {
    logic [7:0] left_speed;
    logic       left_reverse;
    logic [7:0] right_speed;
    logic       right_reverse;
    logic [7:0] distance_error;
  } result_t;

  function automatic logic [3:0] band_speed(input logic [7:0] err);
    logic [3:0] s;
    if (err <= 8'd7) s = 4'd2;
    else if (err <= 8'd10) s = 4'd3;
    else if (err <= 8'd15) s = 4'd5;
    else if (err <= 8'd20) s = 4'd6;
    else if (err <= 8'd30) s = 4'd8;
    else if (err <= 8'd35) s = 4'd9;
    else if (err <= 8'd40) s = 4'd10;
    else if (err <= 8'd50) s = 4'd11;
    else s = 4'd0;
    return s;
  endfunction

endpackage

// ===== rtl/wfs_steer.sv =====
module wfs_steer (
  input  wfs_pkg::cfg_t    cfg_i,
  input  wfs_pkg::item_t   item_i,
  input  logic [2:0]       cooldown_i,
  output wfs_pkg::result_t result_o,
  output logic [2:0]       cooldown_next_o
);

  logic       above;
  logic [7:0] err;
  logic [3:0] turn;
  logic       back;
  logic       hard;
  logic [8:0] sum;
  logic [7:0] sum_sat;
  logic       diff_neg;
  logic [7:0] diff_mag;

  always_comb begin
    above = item_i.distance >= cfg_i.target_distance;
    turn  = 4'd0;
    back  = 1'b0;
    hard  = 1'b0;
    if (item_i.reading_valid) begin
      err = above ? item_i.distance - cfg_i.target_distance
                  : cfg_i.target_distance - item_i.distance;
      if (err > cfg_i.error_tolerance) begin
        back = item_i.wall_side ? above : !above;
        turn = wfs_pkg::band_speed(err);
      end
    end else begin
      err = wfs_pkg::InvalidError;
      if (item_i.distance < wfs_pkg::NearGuessLimit) begin
        turn = wfs_pkg::CloseTurn;
        back = !item_i.wall_side;
      end else if (item_i.distance > wfs_pkg::NearGuessLimit) begin
        turn = wfs_pkg::FarGuessTurn;
        back = item_i.wall_side;
      end
    end

    if (item_i.distance < wfs_pkg::TooCloseLimit) begin
      turn = wfs_pkg::CloseTurn;
      back = !item_i.wall_side;
    end else if (item_i.distance > wfs_pkg::FarLimit && item_i.wall_change_active &&
                 cooldown_i == wfs_pkg::CooldownReady) begin
      hard = 1'b1;
      turn = wfs_pkg::HardTurnSpeed;
      back = !item_i.wall_side;
    end

    if (hard) begin
      cooldown_next_o = 3'd1;
    end else if (cooldown_i < wfs_pkg::CooldownReady) begin
      cooldown_next_o = cooldown_i + 3'd1;
    end else begin
      cooldown_next_o = cooldown_i;
    end

    sum      = {1'b0, cfg_i.forward_speed} + {5'd0, turn};
    sum_sat  = sum[8] ? 8'hFF : sum[7:0];
    diff_neg = cfg_i.forward_speed < {4'd0, turn};
    diff_mag = diff_neg ? {4'd0, turn} - cfg_i.forward_speed
                        : cfg_i.forward_speed - {4'd0, turn};

    if (back) begin
      result_o.left_speed    = sum_sat;
      result_o.left_reverse  = 1'b0;
      result_o.right_speed   = diff_mag;
      result_o.right_reverse = diff_neg;
    end else begin
      result_o.left_speed    = diff_mag;
      result_o.left_reverse  = diff_neg;
      result_o.right_speed   = sum_sat;
      result_o.right_reverse = 1'b0;
    end
    result_o.distance_error = err;
  end

endmodule

// ===== rtl/wall_follow_steering_unit.sv =====
// Wall-following steering for a two-motor robot.
// Input channel: one beat carries one distance reading with its side,
// validity and wall-change flags (in_valid_i / in_stall_o).
// Output channel: one beat carries left and right speed magnitudes, their
// reverse flags and the distance error (out_valid_o / out_stall_i).
// Target distance, forward speed and error tolerance are set through the
// APB port and should only be written while no beat is in flight.
// A beat is captured in an input register, steered by combinational logic,
// and held in the result register, from which it leaves while out_valid_o is
// high and out_stall_i is low; one beat can be accepted every cycle while
// the receiver does not stall.
// The hard-turn cooldown advances when a beat moves into the result
// register. When the receiver stalls, the result holds, the input register
// fills, and in_stall_o rises only once both registers are occupied.
// Reset empties both registers, clears the configuration registers to zero
// and sets the cooldown to its ready value.
module wall_follow_steering_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           wall_side_i,
  input  logic [7:0]                     distance_i,
  input  logic                           reading_valid_i,
  input  logic                           wall_change_active_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     left_speed_o,
  output logic                           left_reverse_o,
  output logic [7:0]                     right_speed_o,
  output logic                           right_reverse_o,
  output logic [7:0]                     distance_error_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wfs_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  wfs_pkg::cfg_t    cfg_q;
  wfs_pkg::item_t   item_q;
  logic             item_valid_q;
  wfs_pkg::result_t result_q;
  wfs_pkg::result_t result_d;
  logic             out_valid_q;
  logic [2:0]       cooldown_q;
  logic [2:0]       cooldown_d;
  logic             advance;
  logic             in_accept;
  logic             cfg_write;
  wfs_pkg::reg_index_e reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = wfs_pkg::reg_index_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      wfs_pkg::REG_TARGET_DISTANCE: prdata = {24'd0, cfg_q.target_distance};
      wfs_pkg::REG_FORWARD_SPEED:   prdata = {24'd0, cfg_q.forward_speed};
      wfs_pkg::REG_ERROR_TOLERANCE: prdata = {24'd0, cfg_q.error_tolerance};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        wfs_pkg::REG_TARGET_DISTANCE: cfg_q.target_distance <= pwdata[7:0];
        wfs_pkg::REG_FORWARD_SPEED:   cfg_q.forward_speed   <= pwdata[7:0];
        wfs_pkg::REG_ERROR_TOLERANCE: cfg_q.error_tolerance <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = item_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  wfs_steer u_steer (
    .cfg_i           (cfg_q),
    .item_i          (item_q),
    .cooldown_i      (cooldown_q),
    .result_o        (result_d),
    .cooldown_next_o (cooldown_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cooldown_q   <= wfs_pkg::CooldownReady;
    end else begin
      if (advance) begin
        out_valid_q <= item_valid_q;
        if (item_valid_q) begin
          cooldown_q <= cooldown_d;
        end
      end
      if (!item_valid_q || advance) begin
        item_valid_q <= in_accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.wall_side          <= wall_side_i;
      item_q.distance           <= distance_i;
      item_q.reading_valid      <= reading_valid_i;
      item_q.wall_change_active <= wall_change_active_i;
    end
    if (advance && item_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_speed_o     = result_q.left_speed;
  assign left_reverse_o   = result_q.left_reverse;
  assign right_speed_o    = result_q.right_speed;
  assign right_reverse_o  = result_q.right_reverse;
  assign distance_error_o = result_q.distance_error;

endmodule

// ===== dv/wall_follow_steering_unit_test.sv =====
`timescale 1ns / 100ps

module wall_follow_steering_unit_test;

  class steering_scoreboard;
    logic [7:0] target;
    logic [7:0] cruise;
    logic [7:0] tolerance;
    logic [2:0] cooldown;
    wfs_pkg::result_t motor_q[$];
    int unsigned fails;
    int unsigned matched;

    function new();
      target    = '0;
      cruise    = '0;
      tolerance = '0;
      cooldown  = wfs_pkg::CooldownReady;
      fails     = 0;
      matched   = 0;
    endfunction

    function void set_reg(wfs_pkg::reg_index_e idx, logic [7:0] v);
      case (idx)
        wfs_pkg::REG_TARGET_DISTANCE: target = v;
        wfs_pkg::REG_FORWARD_SPEED:   cruise = v;
        wfs_pkg::REG_ERROR_TOLERANCE: tolerance = v;
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fails++;
    endtask

    function int turn_rate(logic [7:0] err);
      int bound [8] = '{7, 10, 15, 20, 30, 35, 40, 50};
      int rate [8]  = '{2, 3, 5, 6, 8, 9, 10, 11};
      for (int i = 0; i < 8; i++) begin
        if (err <= bound[i]) return rate[i];
      end
      return 0;
    endfunction

    function void motor(int v, output logic [7:0] spd, output logic rev);
      int mag;
      rev = (v < 0);
      mag = (v < 0) ? -v : v;
      spd = (mag > 255) ? 8'd255 : mag[7:0];
    endfunction

    function void note_input(wfs_pkg::item_t it);
      logic [7:0] err;
      int         turn;
      bit         back;
      bit         above;
      int         lin;
      int         ang;
      wfs_pkg::result_t r;
      turn = 0;
      back = 0;
      if (it.reading_valid) begin
        above = (it.distance >= target);
        err = above ? it.distance - target : target - it.distance;
        if (err > tolerance) begin
          back = it.wall_side ? above : !above;
          turn = turn_rate(err);
        end
      end else begin
        if (it.distance < wfs_pkg::NearGuessLimit) begin
          turn = int'(wfs_pkg::CloseTurn);
          back = !it.wall_side;
        end else if (it.distance > wfs_pkg::NearGuessLimit) begin
          turn = int'(wfs_pkg::FarGuessTurn);
          back = it.wall_side;
        end
        err = wfs_pkg::InvalidError;
      end
      if (it.distance < wfs_pkg::TooCloseLimit) begin
        turn = int'(wfs_pkg::CloseTurn);
        back = !it.wall_side;
      end else if (it.distance > wfs_pkg::FarLimit && it.wall_change_active &&
                   cooldown == wfs_pkg::CooldownReady) begin
        cooldown = '0;
        turn = int'(wfs_pkg::HardTurnSpeed);
        back = !it.wall_side;
      end
      if (cooldown < wfs_pkg::CooldownReady) cooldown = cooldown + 3'd1;
      lin = int'(cruise);
      ang = back ? -turn : turn;
      motor(lin - ang, r.left_speed, r.left_reverse);
      motor(lin + ang, r.right_speed, r.right_reverse);
      r.distance_error = err;
      motor_q.push_back(r);
    endfunction

    task check_result(wfs_pkg::result_t got);
      wfs_pkg::result_t exp;
      if (motor_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      exp = motor_q.pop_front();
      if (got.left_speed !== exp.left_speed)
        report($sformatf("left_speed %0d, expected %0d", got.left_speed, exp.left_speed));
      if (got.left_reverse !== exp.left_reverse)
        report($sformatf("left_reverse %0b, expected %0b", got.left_reverse,
                         exp.left_reverse));
      if (got.right_speed !== exp.right_speed)
        report($sformatf("right_speed %0d, expected %0d", got.right_speed,
                         exp.right_speed));
      if (got.right_reverse !== exp.right_reverse)
        report($sformatf("right_reverse %0b, expected %0b", got.right_reverse,
                         exp.right_reverse));
      if (got.distance_error !== exp.distance_error)
        report($sformatf("distance_error %0d, expected %0d", got.distance_error,
                         exp.distance_error));
      matched++;
    endtask
  endclass

  localparam int unsigned StallLimit = 1000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           wall_side_i;
  logic [7:0]                     distance_i;
  logic                           reading_valid_i;
  logic                           wall_change_active_i;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [7:0]                     left_speed_o;
  logic                           left_reverse_o;
  logic [7:0]                     right_speed_o;
  logic                           right_reverse_o;
  logic [7:0]                     distance_error_o;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [wfs_pkg::PaddrWidth-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  steering_scoreboard sb = new();
  bit          steady;
  int unsigned readings_in = 0;
  int unsigned settings_used;
  int unsigned quiet_cycles = 0;

  wall_follow_steering_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 28);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_input('{wall_side: wall_side_i, distance: distance_i,
                      reading_valid: reading_valid_i,
                      wall_change_active: wall_change_active_i});
      readings_in++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{left_speed: left_speed_o, left_reverse: left_reverse_o,
                        right_speed: right_speed_o, right_reverse: right_reverse_o,
                        distance_error: distance_error_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("timeout after %0d cycles without a beat", StallLimit);
        $display("wall_follow_steering_unit_test: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task apb_write(wfs_pkg::reg_index_e idx, logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'd0, v})
      sb.report($sformatf("register %s reads %0h, expected %0h", idx.name(), prdata, v));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task program_regs(logic [7:0] tgt, logic [7:0] fwd, logic [7:0] tol);
    apb_write(wfs_pkg::REG_TARGET_DISTANCE, tgt);
    apb_write(wfs_pkg::REG_FORWARD_SPEED, fwd);
    apb_write(wfs_pkg::REG_ERROR_TOLERANCE, tol);
    settings_used++;
  endtask

  task send_reading(wfs_pkg::item_t it);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    wall_side_i          <= it.wall_side;
    distance_i           <= it.distance;
    reading_valid_i      <= it.reading_valid;
    wall_change_active_i <= it.wall_change_active;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.motor_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function wfs_pkg::item_t mk(bit side, logic [7:0] d, bit ok, bit changing);
    return '{wall_side: side, distance: d, reading_valid: ok, wall_change_active: changing};
  endfunction

  function wfs_pkg::item_t rand_reading();
    wfs_pkg::item_t it;
    int    pick;
    int    d;
    pick = $urandom_range(0, 99);
    it.wall_side          = 1'($urandom_range(0, 1));
    it.reading_valid      = ($urandom_range(0, 99) < 80);
    it.wall_change_active = ($urandom_range(0, 99) < 30);
    if (pick < 40) begin
      d = int'(sb.target) + int'($urandom_range(0, 120)) - 60;
      d = (d < 0) ? 0 : ((d > 255) ? 255 : d);
    end else if (pick < 55) begin
      d = $urandom_range(0, 25);
    end else if (pick < 75) begin
      d = $urandom_range(55, 255);
      it.wall_change_active = ($urandom_range(0, 99) < 70);
    end else begin
      d = $urandom_range(0, 255);
    end
    it.distance = d[7:0];
    return it;
  endfunction

  initial begin
    wfs_pkg::item_t directed [$];
    logic [7:0] tgt;
    logic [7:0] fwd;
    logic [7:0] tol;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    wall_side_i = 1'b0;
    distance_i = '0;
    reading_valid_i = 1'b0;
    wall_change_active_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    settings_used = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(8'd30, 8'd100, 8'd2);
    directed = '{mk(0, 30, 1, 0), mk(1, 32, 1, 0), mk(0, 33, 1, 0), mk(1, 23, 1, 0),
                 mk(0, 40, 1, 0), mk(1, 15, 1, 0), mk(0, 50, 1, 0), mk(1, 60, 1, 0),
                 mk(0, 65, 1, 0), mk(1, 70, 1, 0), mk(0, 80, 1, 0), mk(1, 81, 1, 0),
                 mk(0, 255, 1, 0), mk(0, 19, 0, 0), mk(1, 20, 0, 0), mk(0, 21, 0, 1),
                 mk(1, 0, 0, 0), mk(0, 6, 1, 0), mk(1, 7, 1, 0), mk(0, 61, 1, 1),
                 mk(1, 200, 0, 1), mk(0, 100, 1, 1), mk(1, 100, 1, 1), mk(1, 255, 0, 1)};
    foreach (directed[i]) send_reading(directed[i]);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin tgt = 8'd0;   fwd = 8'd0;   tol = 8'd0;   end
        1: begin tgt = 8'd255; fwd = 8'd255; tol = 8'd255; end
        2: begin tgt = 8'd40;  fwd = 8'd255; tol = 8'd0;   end
        3: begin tgt = 8'd255; fwd = 8'd0;   tol = 8'd0;   end
        4: begin tgt = 8'd0;   fwd = 8'd255; tol = 8'd1;   end
        default: begin
          tgt = 8'($urandom_range(20, 120));
          fwd = 8'($urandom_range(0, 255));
          tol = 8'($urandom_range(0, 10));
        end
      endcase
      program_regs(tgt, fwd, tol);
      steady = (p == 2);
      repeat (150) send_reading(rand_reading());
      drain();
      steady = 1'b0;
    end

    if (sb.motor_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.motor_q.size()));
    $display("Steered %0d readings under %0d register settings; %0d results checked.",
             readings_in, settings_used, sb.matched);
    if (sb.fails == 0) begin
      $display("wall_follow_steering_unit_test: PASS");
    end else begin
      $display("%0d mismatches", sb.fails);
      $display("wall_follow_steering_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== wall_follow_steering_unit.f =====
rtl/wfs_pkg.sv
rtl/wfs_steer.sv
rtl/wall_follow_steering_unit.sv
dv/wall_follow_steering_unit_test.sv
